// ===== src/tcw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants for the text console writer
// Field widths, command and control codes, and the command plan record that
// the decoder hands to the sequencer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // screen geometry defaults
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // field widths fixed by the word layout
  localparam int CMD_W  = 2;
  localparam int CHAR_W = 8;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CELL_W = 16;
  // widest cell address that the column and row fields can reach
  localparam int CELL_ADDR_W = COL_W + ROW_W;

  // word widths on the stream ports
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 32;

  typedef logic [CMD_W-1:0]       cmd_t;
  typedef logic [CHAR_W-1:0]      byte_t;
  typedef logic [COL_W-1:0]       col_t;
  typedef logic [ROW_W-1:0]       row_t;
  typedef logic [CELL_W-1:0]      cell_t;
  typedef logic [CELL_ADDR_W-1:0] cell_addr_t;

  // commands
  localparam cmd_t CMD_PUT  = 2'd0;
  localparam cmd_t CMD_SET  = 2'd1;
  localparam cmd_t CMD_READ = 2'd2;

  // control characters
  localparam byte_t CH_BEL = 8'd7;
  localparam byte_t CH_BS  = 8'd8;
  localparam byte_t CH_TAB = 8'd9;
  localparam byte_t CH_LF  = 8'd10;
  localparam byte_t CH_FF  = 8'd12;
  localparam byte_t CH_CR  = 8'd13;
  localparam byte_t CH_SPACE = 8'h20;

  localparam byte_t BLANK_ATTR = 8'h0F;
  localparam cell_t BLANK_CELL = {BLANK_ATTR, CH_SPACE};

  // tab stop distance
  localparam int TAB_STEP = 4;

  // what one command needs from the sequencer
  typedef struct packed {
    logic       scroll;     // scroll the screen up one row first
    logic       do_write;   // write wr_data at wr_addr (after any scroll)
    logic       is_read;    // read the cell at rd_addr
    logic       beep;
    col_t       new_col;
    row_t       new_row;
    cell_addr_t wr_addr;
    cell_t      wr_data;
    cell_addr_t attr_addr;  // cell whose attribute colors the new bottom row
    cell_addr_t rd_addr;
  } plan_t;

endpackage

// ===== src/text_console_writer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer: text screen store with cursor
// Character-cell screen (attribute high byte, character low byte) driven by
// put / set-cursor / read commands, with scrolling at the bottom row.
// ----------------------------------------------------------------------------
// Usage and timing: after reset the block runs a clearing pass that writes
// the blank cell (attribute 0x0F, space) into all ROWS*COLUMNS cells, one
// cell per clock; in_tready stays low until it ends.
// One command word is then processed at a time and in_tready is low while it
// is at work. The screen is a single memory with one write and one registered
// read port. A set cursor or a control code with no cell access goes straight
// to the response step, a put or backspace passes through the write step and
// a read through the read step. A newline, return, form feed or character that
// must scroll reads the fill attribute, moves (ROWS-1)*COLUMNS cells up a row
// through the memory one per cycle and then refills the bottom row one cell
// per cycle, before the write step for a character and then the response step.
// A result held by out_tready low stalls the response step until it drains.
// A new command is accepted while the previous result still waits in the
// output register.
// ----------------------------------------------------------------------------
module text_console_writer #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,  // 8 .. 128
  parameter int ROWS    = tcw_pkg::ROWS_DEF      // 2 .. 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // command words
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [7:0] char_code, [15:8] colour, [22:16] pos_x, [27:23] pos_y, rest zero
  input  logic [tcw_pkg::IN_DATA_W-1:0]    in_tdata,
  // [1:0] cmd
  input  tcw_pkg::cmd_t                    in_tuser,
  // result words
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [6:0] cursor_col, [11:7] cursor_row, [12] beep, [28:13] cell_data, rest zero
  output logic [tcw_pkg::OUT_DATA_W-1:0]   out_tdata
);
  import tcw_pkg::*;

  localparam int DEPTH = COLUMNS * ROWS;
  localparam int AW    = $clog2(DEPTH);

  localparam logic [AW-1:0] COLS_A     = AW'(COLUMNS);
  localparam logic [AW-1:0] LAST_A     = AW'(DEPTH - 1);
  localparam logic [AW-1:0] LROW_A     = AW'((ROWS - 1) * COLUMNS);

  // sequencer states
  localparam logic [3:0] S_CLEAR    = 4'd0;   // post-reset blanking pass
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_ATTR_RD  = 4'd2;   // read cell that colors new row
  localparam logic [3:0] S_ATTR_WT  = 4'd3;
  localparam logic [3:0] S_COPY     = 4'd4;   // move rows up, one cell/cycle
  localparam logic [3:0] S_COPY_END = 4'd5;   // last pending copy write
  localparam logic [3:0] S_FILL     = 4'd6;   // blank the bottom row
  localparam logic [3:0] S_WRITE    = 4'd7;
  localparam logic [3:0] S_READ_RD  = 4'd8;
  localparam logic [3:0] S_RESP     = 4'd9;

  logic [3:0]    state_r, state_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  col_t          cur_col_r, cur_col_nxt;
  row_t          cur_row_r, cur_row_nxt;
  plan_t         plan_r, plan_nxt;
  plan_t         plan_in;
  byte_t         attr_r, attr_nxt;
  logic          cpy_vld_r, cpy_vld_nxt;
  logic [AW-1:0] cpy_dst_r, cpy_dst_nxt;
  logic          out_vld_r, out_vld_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  // screen memory
  cell_t         mem [DEPTH];
  cell_t         rd_data_r;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  cell_t         mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;

  logic  in_fire;
  cell_t cell_val;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  tcw_plan #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_plan (
    .cmd       (in_tuser),
    .char_code (in_tdata[7:0]),
    .colour    (in_tdata[15:8]),
    .pos_x     (in_tdata[22:16]),
    .pos_y     (in_tdata[27:23]),
    .cur_col   (cur_col_r),
    .cur_row   (cur_row_r),
    .plan      (plan_in)
  );

  // memory port steering
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt_r;
    mem_wdata = BLANK_CELL;
    mem_re    = 1'b0;
    mem_raddr = cnt_r;
    case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_ATTR_RD: begin
        mem_re    = 1'b1;
        mem_raddr = plan_r.attr_addr[AW-1:0];
      end
      S_COPY: begin
        mem_re    = 1'b1;
        mem_we    = cpy_vld_r;
        mem_waddr = cpy_dst_r;
        mem_wdata = rd_data_r;
      end
      S_COPY_END: begin
        mem_we    = cpy_vld_r;
        mem_waddr = cpy_dst_r;
        mem_wdata = rd_data_r;
      end
      S_FILL: begin
        mem_we    = 1'b1;
        mem_wdata = {attr_r, CH_SPACE};
      end
      S_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = plan_r.wr_addr[AW-1:0];
        mem_wdata = plan_r.wr_data;
      end
      S_READ_RD: begin
        mem_re    = 1'b1;
        mem_raddr = plan_r.rd_addr[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data_r <= mem[mem_raddr];
  end

  // only a read command reports a cell
  assign cell_val = plan_r.is_read ? rd_data_r : '0;

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    cur_col_nxt  = cur_col_r;
    cur_row_nxt  = cur_row_r;
    plan_nxt     = plan_r;
    attr_nxt     = attr_r;
    cpy_vld_nxt  = 1'b0;
    cpy_dst_nxt  = cnt_r - COLS_A;
    out_vld_nxt  = out_vld_r && !out_tready;
    out_data_nxt = out_data_r;

    case (state_r)
      S_CLEAR: begin
        cnt_nxt = cnt_r + AW'(1);
        if (cnt_r == LAST_A) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_fire) begin
          plan_nxt    = plan_in;
          cur_col_nxt = plan_in.new_col;
          cur_row_nxt = plan_in.new_row;
          if (plan_in.scroll)        state_nxt = S_ATTR_RD;
          else if (plan_in.do_write) state_nxt = S_WRITE;
          else if (plan_in.is_read)  state_nxt = S_READ_RD;
          else                       state_nxt = S_RESP;
        end
      end
      S_ATTR_RD: begin
        state_nxt = S_ATTR_WT;
      end
      S_ATTR_WT: begin
        attr_nxt  = rd_data_r[CELL_W-1:CHAR_W];
        cnt_nxt   = COLS_A;
        state_nxt = S_COPY;
      end
      S_COPY: begin
        // read source now, write it one row up next cycle
        cpy_vld_nxt = 1'b1;
        cnt_nxt     = cnt_r + AW'(1);
        if (cnt_r == LAST_A) state_nxt = S_COPY_END;
      end
      S_COPY_END: begin
        cnt_nxt   = LROW_A;
        state_nxt = S_FILL;
      end
      S_FILL: begin
        cnt_nxt = cnt_r + AW'(1);
        if (cnt_r == LAST_A) state_nxt = plan_r.do_write ? S_WRITE : S_RESP;
      end
      S_WRITE: begin
        state_nxt = S_RESP;
      end
      S_READ_RD: begin
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_vld_r || out_tready) begin
          out_vld_nxt  = 1'b1;
          out_data_nxt = OUT_DATA_W'({cell_val, plan_r.beep, cur_row_r, cur_col_r});
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      cnt_r     <= '0;
      cur_col_r <= '0;
      cur_row_r <= '0;
      cpy_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      cur_col_r <= cur_col_nxt;
      cur_row_r <= cur_row_nxt;
      cpy_vld_r <= cpy_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    plan_r     <= plan_nxt;
    attr_r     <= attr_nxt;
    cpy_dst_r  <= cpy_dst_nxt;
    out_data_r <= out_data_nxt;
  end

  // cursor stays on the screen
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_col_r <= COL_W'(COLUMNS - 1)) && (cur_row_r <= ROW_W'(ROWS - 1)))
    else $error("cursor off screen");

  // no screen write while waiting for a command
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !mem_we)
    else $error("memory write in idle");

  // an accepted command blocks the input until it is done
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("input ready right after accept");

  // a result appears only from the response step
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(state_r == S_RESP))
    else $error("result raised outside response step");

  // copy writes only happen during the scroll move
  a_copy_window: assert property (@(posedge clk) disable iff (!rst_n)
    cpy_vld_r |-> (state_r == S_COPY || state_r == S_COPY_END))
    else $error("copy write outside scroll");

endmodule

// ===== src/tcw_plan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_plan: command decoder
// Turns one command and the current cursor into a plan: new cursor, whether
// to scroll, which cell to write or read, and the beep flag.
// ----------------------------------------------------------------------------
module tcw_plan #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  tcw_pkg::cmd_t  cmd,
  input  tcw_pkg::byte_t char_code,
  input  tcw_pkg::byte_t colour,
  input  tcw_pkg::col_t  pos_x,
  input  tcw_pkg::row_t  pos_y,
  input  tcw_pkg::col_t  cur_col,
  input  tcw_pkg::row_t  cur_row,
  output tcw_pkg::plan_t plan
);
  import tcw_pkg::*;

  localparam col_t LAST_COL = COL_W'(COLUMNS - 1);
  localparam row_t LAST_ROW = ROW_W'(ROWS - 1);

  function automatic cell_addr_t addr_of(input row_t r, input col_t c);
    cell_addr_t prod;
    prod = CELL_ADDR_W'(r) * CELL_ADDR_W'(COLUMNS);
    return prod + CELL_ADDR_W'(c);
  endfunction

  logic [COL_W:0] col_step;
  col_t           tab_col;
  col_t           put_col;
  col_t           clamp_x;
  row_t           clamp_y;
  col_t           bs_col;
  row_t           bs_row;
  logic           at_last_row;

  always_comb begin
    col_step    = {1'b0, cur_col} + (COL_W+1)'(TAB_STEP);
    tab_col     = (col_step > (COL_W+1)'(COLUMNS - 1)) ? LAST_COL : col_step[COL_W-1:0];
    put_col     = (char_code == CH_TAB) ? tab_col : cur_col;
    clamp_x     = (pos_x > LAST_COL) ? LAST_COL : pos_x;
    clamp_y     = (pos_y > LAST_ROW) ? LAST_ROW : pos_y;
    at_last_row = (cur_row == LAST_ROW);
    // backspace target: wraps to the end of the row above
    if (cur_col == '0) begin
      bs_col = LAST_COL;
      bs_row = cur_row - ROW_W'(1);
    end else begin
      bs_col = cur_col - COL_W'(1);
      bs_row = cur_row;
    end

    plan         = '0;
    plan.new_col = cur_col;
    plan.new_row = cur_row;

    case (cmd)
      CMD_PUT: begin
        if (char_code == CH_LF || char_code == CH_CR || char_code == CH_FF) begin
          plan.scroll    = at_last_row;
          plan.attr_addr = addr_of(LAST_ROW, cur_col);
          if (!at_last_row) plan.new_row = cur_row + ROW_W'(1);
          if (char_code != CH_FF) plan.new_col = '0;
        end else if (char_code == CH_BEL) begin
          plan.beep = 1'b1;
        end else if (char_code == CH_BS) begin
          if (!(cur_row == '0 && cur_col == '0)) begin
            plan.new_col  = bs_col;
            plan.new_row  = bs_row;
            plan.do_write = 1'b1;
            plan.wr_addr  = addr_of(bs_row, bs_col);
            plan.wr_data  = BLANK_CELL;
          end
        end else begin
          // any other byte is written; tab writes its own code at the tab stop
          plan.scroll    = (put_col == LAST_COL) && at_last_row;
          plan.attr_addr = addr_of(LAST_ROW, put_col);
          plan.do_write  = 1'b1;
          plan.wr_addr   = addr_of(cur_row, put_col);
          plan.wr_data   = {colour, char_code};
          if (put_col == LAST_COL) begin
            plan.new_col = '0;
            if (!at_last_row) plan.new_row = cur_row + ROW_W'(1);
          end else begin
            plan.new_col = put_col + COL_W'(1);
          end
        end
      end
      CMD_SET: begin
        plan.new_col = clamp_x;
        plan.new_row = clamp_y;
      end
      CMD_READ: begin
        plan.is_read = 1'b1;
        plan.rd_addr = addr_of(clamp_y, clamp_x);
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for text_console_writer
// Feeds put, set-cursor and read command words through the input stream and
// compares each status word with a shadow screen and cursor kept here. Starts
// with a short directed pass over the corner cases, then runs a long random
// pass of text runs, cursor moves and read-backs. Sender bursts and receiver
// stalls are random, with two long output hold-offs so the block backs up.
// ----------------------------------------------------------------------------
module tb_top;
  import tcw_pkg::*;

  localparam int NCOL  = COLUMNS_DEF;
  localparam int NROW  = ROWS_DEF;
  localparam int NCELL = NCOL * NROW;

  // cmd code the block must ignore (status only, no state change)
  localparam cmd_t CMD_NONE = 2'd3;

  localparam int RANDOM_WORDS = 1800;
  localparam int HOLD_CYCLES  = 300;   // long output hold-off
  localparam int DRAIN_CYCLES = 20;    // settle time after the last status word
  localparam int DRAIN_LIMIT  = 50000; // bound on waiting for outstanding words
  localparam int PRINT_LIMIT  = 50;    // mismatch lines printed before going quiet

  localparam byte_t CTRL_CODES [6] = '{CH_BEL, CH_BS, CH_TAB, CH_LF, CH_FF, CH_CR};

  // receiver stall styles
  typedef enum int {RX_STEADY, RX_MOSTLY, RX_PATTERN, RX_SPARSE} rx_mode_t;

  // one status word as the block should report it
  typedef struct {
    col_t  col;
    row_t  row;
    logic  beep;
    cell_t cell_data;
  } status_word_t;

  // --------------------------------------------------------------------------
  // Shadow screen: tracks the cells and cursor as the accepted commands should
  // leave them and queues the status word each command must produce.
  // --------------------------------------------------------------------------
  class console_scoreboard;
    cell_t        shadow_cells [NCELL];
    int           cur_col;
    int           cur_row;
    status_word_t due_status [$];
    int           errors;

    function new();
      for (int i = 0; i < NCELL; i++) shadow_cells[i] = BLANK_CELL;
      cur_col = 0;
      cur_row = 0;
      errors  = 0;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= PRINT_LIMIT) $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    // move every row up by one; the new bottom row is blank in the attribute
    // found under the cursor column on the old bottom row
    function void scroll_up();
      byte_t fill_attr;
      fill_attr = shadow_cells[(NROW - 1) * NCOL + cur_col][15:8];
      for (int i = 0; i < (NROW - 1) * NCOL; i++) shadow_cells[i] = shadow_cells[i + NCOL];
      for (int i = 0; i < NCOL; i++) shadow_cells[(NROW - 1) * NCOL + i] = {fill_attr, CH_SPACE};
    endfunction

    function void line_feed();
      if (cur_row >= NROW - 1) scroll_up();
      else cur_row++;
    endfunction

    // returns the beep flag
    function logic put_char(byte_t ch, byte_t attr);
      case (ch)
        CH_LF, CH_CR: begin
          line_feed();
          cur_col = 0;
          return 1'b0;
        end
        CH_FF: begin
          line_feed();
          return 1'b0;
        end
        CH_BEL: return 1'b1;
        CH_BS: begin
          if (cur_row == 0 && cur_col == 0) return 1'b0;
          if (cur_col == 0) begin
            cur_row--;
            cur_col = NCOL - 1;
          end else begin
            cur_col--;
          end
          shadow_cells[cur_row * NCOL + cur_col] = BLANK_CELL;
          return 1'b0;
        end
        default: ;
      endcase
      // tab jumps ahead then lands like a printable byte
      if (ch == CH_TAB)
        cur_col = (cur_col + TAB_STEP > NCOL - 1) ? NCOL - 1 : cur_col + TAB_STEP;
      if (cur_col == NCOL - 1 && cur_row == NROW - 1) scroll_up();
      shadow_cells[cur_row * NCOL + cur_col] = {attr, ch};
      cur_col++;
      if (cur_col >= NCOL) begin
        cur_col = 0;
        if (cur_row < NROW - 1) cur_row++;
      end
      return 1'b0;
    endfunction

    function void note_command(cmd_t cmd, logic [IN_DATA_W-1:0] word);
      status_word_t st;
      int           x;
      int           y;
      x = (int'(word[22:16]) > NCOL - 1) ? NCOL - 1 : int'(word[22:16]);
      y = (int'(word[27:23]) > NROW - 1) ? NROW - 1 : int'(word[27:23]);
      st.beep      = 1'b0;
      st.cell_data = '0;
      case (cmd)
        CMD_PUT:  st.beep = put_char(word[7:0], word[15:8]);
        CMD_SET: begin
          cur_col = x;
          cur_row = y;
        end
        CMD_READ: st.cell_data = shadow_cells[y * NCOL + x];
        default: ;
      endcase
      st.col = col_t'(cur_col);
      st.row = row_t'(cur_row);
      due_status.push_back(st);
    endfunction

    task check_status_word(logic [OUT_DATA_W-1:0] word);
      status_word_t st;
      if (due_status.size() == 0) begin
        report($sformatf("status word %h with no command outstanding", word));
        return;
      end
      st = due_status.pop_front();
      if (word[6:0] !== st.col)
        report($sformatf("cursor_col %0d, want %0d", word[6:0], st.col));
      if (word[11:7] !== st.row)
        report($sformatf("cursor_row %0d, want %0d", word[11:7], st.row));
      if (word[12] !== st.beep)
        report($sformatf("beep %b, want %b", word[12], st.beep));
      if (word[28:13] !== st.cell_data)
        report($sformatf("cell_data %h, want %h", word[28:13], st.cell_data));
      if (word[OUT_DATA_W-1:29] !== '0)
        report($sformatf("pad bits %b not zero", word[OUT_DATA_W-1:29]));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  cmd_t                  in_tuser   = CMD_PUT;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  text_console_writer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  console_scoreboard sb;

  // sender burst state; tx_on mirrors in_tvalid so the end of the run knows
  // whether the last word still holds it high
  int burst_left = 0;
  bit tx_on      = 1'b0;

  // receiver state; hold_ask is raised by the stimulus to start a hold-off
  bit       hold_ask  = 1'b0;
  int       hold_left = 0;
  int       mode_left = 0;
  rx_mode_t rx_mode   = RX_STEADY;

  // --------------------------------------------------------------------------
  // Receiver: switches between stall styles now and then. A hold request
  // keeps out_tready low long enough that the result register and the command
  // in flight back up and in_tready drops while words keep coming.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else if (hold_ask) begin
      hold_ask  = 1'b0;
      hold_left = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(50, 400);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        RX_STEADY:  out_tready <= 1'b1;
        RX_MOSTLY:  out_tready <= ($urandom_range(0, 3) != 0);
        RX_PATTERN: out_tready <= ((mode_left % 5) < 2);
        default:    out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // status words are checked on the edge that accepts them
  always @(posedge clk) begin
    if (rst_n && out_tvalid === 1'b1 && out_tready === 1'b1) sb.check_status_word(out_tdata);
  end

  // --------------------------------------------------------------------------
  // Sender. A word is offered until accepted, then noted in the shadow screen
  // on that same edge. Between bursts valid drops; a long burst now and then
  // gives stretches with no sender idling at all.
  // --------------------------------------------------------------------------
  task automatic send_cmd(cmd_t cmd, byte_t ch, byte_t attr, int x, int y);
    logic [IN_DATA_W-1:0] word;
    word = {4'b0, y[4:0], x[6:0], attr, ch};
    in_tdata  <= word;
    in_tuser  <= cmd;
    in_tvalid <= 1'b1;
    tx_on = 1'b1;
    do @(posedge clk); while (in_tready !== 1'b1);
    sb.note_command(cmd, word);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_tvalid <= 1'b0;
      tx_on = 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 15);
    end
  endtask

  // Random word: mostly printable text runs at the cursor, cursor moves that
  // stay above the bottom row, and reads that land on freshly written cells.
  // Line breaks on the bottom row are mostly swapped for text so scrolls
  // stay a small share of the run.
  task automatic send_random();
    int    pick;
    int    x;
    int    y;
    byte_t ch;
    byte_t attr;
    cmd_t  cmd;
    pick = $urandom_range(0, 99);
    ch   = byte_t'($urandom_range(0, 255));
    attr = byte_t'($urandom_range(0, 255));
    x    = $urandom_range(0, 127);
    y    = $urandom_range(0, 31);
    if (pick < 55) begin
      cmd = CMD_PUT;
      case ($urandom_range(0, 9))
        0, 1, 2: ;                                  // any byte at all
        3, 4:    ch = CTRL_CODES[$urandom_range(0, 5)];
        default: ch = byte_t'($urandom_range(8'h20, 8'h7E)); // plain text
      endcase
      if (sb.cur_row == NROW - 1 && (ch == CH_LF || ch == CH_CR || ch == CH_FF) &&
          $urandom_range(0, 3) != 0)
        ch = byte_t'($urandom_range(8'h20, 8'h7E));
    end else if (pick < 75) begin
      cmd = CMD_SET;
      case ($urandom_range(0, 9))
        0:       x = 0;                          // line start: backspace climbs
        1, 2:    ;                               // full range, clamped
        default: x = $urandom_range(0, NCOL - 1);
      endcase
      if ($urandom_range(0, 19) < 17) y = $urandom_range(0, NROW - 2);
    end else if (pick < 97) begin
      cmd = CMD_READ;
      if ($urandom_range(0, 1) == 1) begin
        // cell just written (or blanked) behind the cursor
        x = (sb.cur_col == 0) ? 0 : sb.cur_col - 1;
        y = sb.cur_row;
      end
    end else begin
      cmd = CMD_NONE;
    end
    send_cmd(cmd, ch, attr, x, y);
  endtask

  // Corner cases first: clamping, backspace at home and at line start, tab
  // saturation, bell, scrolls from line breaks and from the last cell, fill
  // attribute of a scrolled-in row, and the unused command code.
  task automatic run_directed();
    send_cmd(CMD_READ, 8'h00, 8'h00, 0, 0);      // fresh screen reads blank
    send_cmd(CMD_READ, 8'hFF, 8'hFF, 127, 31);   // read position clamps
    send_cmd(CMD_PUT, CH_BS, 8'h00, 0, 0);       // backspace at home: no effect
    send_cmd(CMD_PUT, 8'hFF, 8'hFF, 0, 0);       // all-ones byte and attribute
    send_cmd(CMD_PUT, CH_BEL, 8'h33, 0, 0);      // bell: beep only
    send_cmd(CMD_PUT, CH_TAB, 8'h1E, 0, 0);      // tab lands at column 5
    send_cmd(CMD_READ, 8'h00, 8'h00, 5, 0);
    send_cmd(CMD_SET, 8'h00, 8'h00, 76, 3);
    send_cmd(CMD_PUT, CH_TAB, 8'h4C, 0, 0);      // tab saturates at last column, wraps
    send_cmd(CMD_PUT, CH_BS, 8'h00, 0, 0);       // column 0: climbs to row above
    send_cmd(CMD_SET, 8'h00, 8'h00, 10, 24);
    send_cmd(CMD_PUT, 8'h78, 8'h5A, 0, 0);
    send_cmd(CMD_SET, 8'h00, 8'h00, 10, 24);
    send_cmd(CMD_PUT, CH_LF, 8'h00, 0, 0);       // scroll, fill takes attribute 5A
    send_cmd(CMD_READ, 8'h00, 8'h00, 3, 24);
    send_cmd(CMD_READ, 8'h00, 8'h00, 10, 23);    // written cell moved up a row
    send_cmd(CMD_SET, 8'hFF, 8'hFF, 127, 31);    // clamps to the last cell
    send_cmd(CMD_PUT, 8'h00, 8'h00, 0, 0);       // last cell: scroll first, row holds
    send_cmd(CMD_PUT, CH_FF, 8'h00, 0, 0);       // form feed on bottom row scrolls
    send_cmd(CMD_PUT, CH_CR, 8'h00, 0, 0);       // so does return
    send_cmd(CMD_PUT, CH_BS, 8'h00, 0, 0);       // bottom row, column 0
    send_cmd(CMD_PUT, CH_LF, 8'h00, 0, 0);       // row 23 -> 24, no scroll
    send_cmd(CMD_NONE, 8'hFF, 8'hFF, 127, 31);   // unused command
    send_cmd(CMD_READ, 8'h00, 8'h00, 79, 23);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence. After reset the block clears the screen; the first send
  // just waits on in_tready through that.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int waited;
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    hold_ask = 1'b1;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == RANDOM_WORDS / 2) hold_ask = 1'b1;
      send_random();
    end
    if (tx_on) in_tvalid <= 1'b0;
    waited = 0;
    while (sb.due_status.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (sb.due_status.size() != 0)
      sb.report($sformatf("%0d status words never arrived", sb.due_status.size()));
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("text_console_writer verification clean");
    end else begin
      $display("text_console_writer verification failed");
    end
    $finish;
  end

  // hang guard: far beyond even a run where every word scrolls
  initial begin : watchdog
    #200_000_000;
    $display("text_console_writer verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
src/tcw_pkg.sv
src/tcw_plan.sv
src/text_console_writer.sv
tb/tb_top.sv
